// ----- design/ensc_pkg.sv -----
package ensc_pkg;

  localparam int DIV_W = 32;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_TEMP_CALIB    = 3'd0;
  localparam logic [2:0] REG_PRESS_CALIB_A = 3'd1;
  localparam logic [2:0] REG_PRESS_CALIB_B = 3'd2;
  localparam logic [2:0] REG_PRESS_CALIB_C = 3'd3;
  localparam logic [2:0] REG_HUM_CALIB     = 3'd4;

  localparam logic signed [31:0] TEMP_MIN    = -32'sd4000;
  localparam logic signed [31:0] TEMP_MAX    = 32'sd8500;
  localparam logic [31:0]        PRESS_MIN   = 32'd30000;
  localparam logic [31:0]        PRESS_MAX   = 32'd110000;
  localparam logic signed [31:0] HUM_VAR_MAX = 32'sd419430400;

  // Sideband that rides along the divider with each beat.
  typedef struct packed {
    logic        valid;
    logic        press_en;
    logic        shift;
    logic        zero;
    logic [14:0] temp;
    logic [16:0] hum;
  } side_t;

  // Signed division by 2**k that truncates toward zero.
  function automatic logic signed [31:0] sdiv(input logic signed [31:0] x,
                                               input logic [4:0] k);
    logic signed [31:0] bias;
    bias = x[31] ? $signed((32'd1 << k) - 32'd1) : 32'sd0;
    return (x + bias) >>> k;
  endfunction

endpackage

// ----- design/ensc_div.sv -----
module ensc_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  ensc_pkg::side_t       in_side,
  input  logic [31:0]           in_dvd,
  input  logic [31:0]           in_dvs,
  output ensc_pkg::side_t       out_side,
  output logic [31:0]           out_quo
);

  // One quotient bit per stage, restoring form.
  ensc_pkg::side_t side_r [0:ensc_pkg::DIV_W-1];
  logic [31:0]     rem_r  [0:ensc_pkg::DIV_W-1];
  logic [31:0]     dvd_r  [0:ensc_pkg::DIV_W-1];
  logic [31:0]     dvs_r  [0:ensc_pkg::DIV_W-1];
  logic [31:0]     quo_r  [0:ensc_pkg::DIV_W-1];

  for (genvar i = 0; i < ensc_pkg::DIV_W; i++) begin : g_stage
    ensc_pkg::side_t side_i;
    logic [31:0] rem_i, dvd_i, dvs_i, quo_i;
    logic [32:0] rem_sh, rem_n;
    logic        ge;

    if (i == 0) begin : g_first
      assign side_i = in_side;
      assign rem_i  = '0;
      assign dvd_i  = in_dvd;
      assign dvs_i  = in_dvs;
      assign quo_i  = '0;
    end else begin : g_next
      assign side_i = side_r[i-1];
      assign rem_i  = rem_r[i-1];
      assign dvd_i  = dvd_r[i-1];
      assign dvs_i  = dvs_r[i-1];
      assign quo_i  = quo_r[i-1];
    end

    always_comb begin
      rem_sh = {rem_i, dvd_i[31]};
      ge     = rem_sh >= {1'b0, dvs_i};
      rem_n  = ge ? rem_sh - {1'b0, dvs_i} : rem_sh;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        side_r[i] <= '0;
      end else if (en) begin
        side_r[i] <= side_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_n[31:0];
        dvd_r[i] <= {dvd_i[30:0], 1'b0};
        dvs_r[i] <= dvs_i;
        quo_r[i] <= {quo_i[30:0], ge};
      end
    end
  end

  assign out_side = side_r[ensc_pkg::DIV_W-1];
  assign out_quo  = quo_r[ensc_pkg::DIV_W-1];

endmodule

// ----- design/env_sensor_compensation.sv -----
// Environmental sensor compensation, 32-bit integer scheme.
// Input channel: in_valid / in_stall with raw temperature, pressure, humidity
// and a channel mask in in_func. Output channel: out_valid / out_stall with
// temperature in 0.01 degC, pressure in Pa and humidity in 1/1024 %RH.
// Pressure or humidity reads 0 when its mask bit is clear; any set bit
// computes temperature. Calibration words are written on cfg_we /
// cfg_index / cfg_data; the user must write them only while the block is
// idle, which the block does not enforce; all five registers clear to zero at
// reset. Throughput is one beat per cycle while the receiver does not stall.
// The path holds 46 register stages: 11 arithmetic stages, the 32-stage
// pressure divider with one quotient bit per stage, and 3 stages after it.
// Reset (rst_n low, synchronous) empties the pipeline.
// When the receiver stalls with a result waiting, the whole pipeline freezes
// and in_stall rises in the same cycle; nothing is dropped or repeated.
module env_sensor_compensation (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [19:0]        in_raw_temperature,
  input  logic [19:0]        in_raw_pressure,
  input  logic [15:0]        in_raw_humidity,
  input  logic [2:0]         in_func,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [14:0] out_temp_centi_c,
  output logic [16:0]        out_pressure_pa,
  output logic [16:0]        out_humidity_q10,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  logic [47:0] temp_cal_r;
  logic [63:0] press_a_r, press_b_r, hum_cal_r;
  logic [15:0] press_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      temp_cal_r <= '0;
      press_a_r  <= '0;
      press_b_r  <= '0;
      press_c_r  <= '0;
      hum_cal_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        ensc_pkg::REG_TEMP_CALIB:    temp_cal_r <= cfg_data[47:0];
        ensc_pkg::REG_PRESS_CALIB_A: press_a_r  <= cfg_data;
        ensc_pkg::REG_PRESS_CALIB_B: press_b_r  <= cfg_data;
        ensc_pkg::REG_PRESS_CALIB_C: press_c_r  <= cfg_data[15:0];
        ensc_pkg::REG_HUM_CALIB:     hum_cal_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic signed [31:0] h1, h2, h3, h4, h5, h6;

  assign t1 = $signed({16'b0, temp_cal_r[15:0]});
  assign t2 = $signed({{16{temp_cal_r[31]}}, temp_cal_r[31:16]});
  assign t3 = $signed({{16{temp_cal_r[47]}}, temp_cal_r[47:32]});
  assign p1 = $signed({16'b0, press_a_r[15:0]});
  assign p2 = $signed({{16{press_a_r[31]}}, press_a_r[31:16]});
  assign p3 = $signed({{16{press_a_r[47]}}, press_a_r[47:32]});
  assign p4 = $signed({{16{press_a_r[63]}}, press_a_r[63:48]});
  assign p5 = $signed({{16{press_b_r[15]}}, press_b_r[15:0]});
  assign p6 = $signed({{16{press_b_r[31]}}, press_b_r[31:16]});
  assign p7 = $signed({{16{press_b_r[47]}}, press_b_r[47:32]});
  assign p8 = $signed({{16{press_b_r[63]}}, press_b_r[63:48]});
  assign p9 = $signed({{16{press_c_r[15]}}, press_c_r});
  assign h1 = $signed({24'b0, hum_cal_r[7:0]});
  assign h2 = $signed({{16{hum_cal_r[23]}}, hum_cal_r[23:8]});
  assign h3 = $signed({24'b0, hum_cal_r[31:24]});
  assign h4 = $signed({{20{hum_cal_r[43]}}, hum_cal_r[43:32]});
  assign h5 = $signed({{20{hum_cal_r[55]}}, hum_cal_r[55:44]});
  assign h6 = $signed({{24{hum_cal_r[63]}}, hum_cal_r[63:56]});

  logic en;
  logic out_valid_r;
  logic [10:0] v_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[9:0], in_valid};
    end
  end

  // Carried fields.
  logic [2:0]  fn_r [1:10];
  logic [19:0] rp_r [1:9];
  logic [15:0] rh_r [1:4];
  logic [14:0] temp_r [6:11];

  always_ff @(posedge clk) begin
    if (en) begin
      fn_r[1] <= in_func;
      rp_r[1] <= in_raw_pressure;
      rh_r[1] <= in_raw_humidity;
      for (int i = 2; i <= 10; i++) fn_r[i] <= fn_r[i-1];
      for (int i = 2; i <= 9; i++)  rp_r[i] <= rp_r[i-1];
      for (int i = 2; i <= 4; i++)  rh_r[i] <= rh_r[i-1];
    end
  end

  // Temperature: stages 1 to 5.
  logic signed [31:0] s1_a_r, s1_b_r, s2_ma_r, s2_mb_r, s3_a_r, s3_mb_r, s4_fine_r;
  logic signed [31:0] tt;
  logic [14:0]        t15;

  always_comb begin
    tt = ensc_pkg::sdiv(s4_fine_r * 32'sd5 + 32'sd128, 5'd8);
    if (tt < ensc_pkg::TEMP_MIN) begin
      tt = ensc_pkg::TEMP_MIN;
    end else if (tt > ensc_pkg::TEMP_MAX) begin
      tt = ensc_pkg::TEMP_MAX;
    end
    t15 = (fn_r[4] == 3'd0) ? 15'd0 : tt[14:0];
  end

  // Pressure front end: stages 5 to 11.
  logic signed [31:0] s5_pa_r, s5_pq_r, s6_qq_r, s6_ap5_r, s6_pa2_r;
  logic signed [31:0] s7_b1_r, s7_c1_r, s7_ap_r, s7_d_r, s8_b2_r, s8_cd_r;
  logic signed [31:0] s9_a3_r, s9_b2_r, s10_a4_r;
  logic [31:0]        s10_num_r;
  // Humidity: stages 5 to 11.
  logic signed [31:0] s5_hd_r, s5_hab_r, s5_hc_r, s6_he_r, s6_m6_r, s6_m3_r;
  logic signed [31:0] s7_hm_r, s7_he_r, s8_mc_r, s8_he_r, s9_hb_r, s10_hb_r, s10_cc_r;
  logic signed [31:0] s10_bs, he2;
  logic [16:0]        hum17;

  assign s10_bs = ensc_pkg::sdiv(s9_hb_r, 5'd15);

  always_comb begin
    he2 = s10_hb_r - ensc_pkg::sdiv(ensc_pkg::sdiv(s10_cc_r, 5'd7) * h1, 5'd4);
    if (he2 < 32'sd0) begin
      he2 = 32'sd0;
    end
    if (he2 > ensc_pkg::HUM_VAR_MAX) begin
      he2 = ensc_pkg::HUM_VAR_MAX;
    end
    hum17 = fn_r[10][2] ? he2[28:12] : 17'd0;
  end

  ensc_pkg::side_t s11_side_r;
  logic [31:0]     s11_dvd_r, s11_dvs_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_a_r    <= $signed({15'b0, in_raw_temperature[19:3]}) - (t1 <<< 1);
      s1_b_r    <= $signed({16'b0, in_raw_temperature[19:4]}) - t1;
      s2_ma_r   <= s1_a_r * t2;
      s2_mb_r   <= s1_b_r * s1_b_r;
      s3_a_r    <= ensc_pkg::sdiv(s2_ma_r, 5'd11);
      s3_mb_r   <= ensc_pkg::sdiv(s2_mb_r, 5'd12) * t3;
      s4_fine_r <= s3_a_r + ensc_pkg::sdiv(s3_mb_r, 5'd14);

      temp_r[6] <= t15;
      for (int i = 7; i <= 11; i++) temp_r[i] <= temp_r[i-1];
      s5_pa_r   <= ensc_pkg::sdiv(s4_fine_r, 5'd1) - 32'sd64000;
      s5_pq_r   <= ensc_pkg::sdiv(ensc_pkg::sdiv(s4_fine_r, 5'd1) - 32'sd64000, 5'd2);
      s5_hd_r   <= s4_fine_r - 32'sd76800;
      s5_hab_r  <= $signed({2'b0, rh_r[4], 14'b0}) - (h4 <<< 20);
      s5_hc_r   <= h5 * (s4_fine_r - 32'sd76800);

      s6_qq_r   <= s5_pq_r * s5_pq_r;
      s6_ap5_r  <= s5_pa_r * p5;
      s6_pa2_r  <= p2 * s5_pa_r;
      s6_he_r   <= ensc_pkg::sdiv(s5_hab_r - s5_hc_r + 32'sd16384, 5'd15);
      s6_m6_r   <= s5_hd_r * h6;
      s6_m3_r   <= s5_hd_r * h3;

      s7_b1_r   <= ensc_pkg::sdiv(s6_qq_r, 5'd11) * p6;
      s7_c1_r   <= p3 * ensc_pkg::sdiv(s6_qq_r, 5'd13);
      s7_ap_r   <= s6_ap5_r <<< 1;
      s7_d_r    <= ensc_pkg::sdiv(s6_pa2_r, 5'd1);
      s7_hm_r   <= ensc_pkg::sdiv(s6_m6_r, 5'd10) *
                   (ensc_pkg::sdiv(s6_m3_r, 5'd11) + 32'sd32768);
      s7_he_r   <= s6_he_r;

      s8_b2_r   <= ensc_pkg::sdiv(s7_b1_r + s7_ap_r, 5'd2) + (p4 <<< 16);
      s8_cd_r   <= ensc_pkg::sdiv(ensc_pkg::sdiv(s7_c1_r, 5'd3) + s7_d_r, 5'd18);
      s8_mc_r   <= (ensc_pkg::sdiv(s7_hm_r, 5'd10) + 32'sd2097152) * h2;
      s8_he_r   <= s7_he_r;

      s9_a3_r   <= (32'sd32768 + s8_cd_r) * p1;
      s9_b2_r   <= s8_b2_r;
      s9_hb_r   <= s8_he_r * ensc_pkg::sdiv(s8_mc_r + 32'sd8192, 5'd14);

      s10_a4_r  <= ensc_pkg::sdiv(s9_a3_r, 5'd15);
      s10_num_r <= (32'd1048576 - {12'b0, rp_r[9]} -
                    $unsigned(ensc_pkg::sdiv(s9_b2_r, 5'd12))) * 32'd3125;
      s10_hb_r  <= s9_hb_r;
      s10_cc_r  <= s10_bs * s10_bs;

      s11_dvd_r <= s10_num_r[31] ? s10_num_r : {s10_num_r[30:0], 1'b0};
      s11_dvs_r <= $unsigned(s10_a4_r);
      s11_side_r.press_en <= fn_r[10][1];
      s11_side_r.shift    <= s10_num_r[31];
      s11_side_r.zero     <= (s10_a4_r == 32'sd0);
      s11_side_r.temp     <= temp_r[11];
      s11_side_r.hum      <= hum17;
    end
  end

  // Valid of stage 11 lives in v_r; the sideband copy is built from it.
  ensc_pkg::side_t div_in_side;
  always_comb begin
    div_in_side.valid    = v_r[10];
    div_in_side.press_en = s11_side_r.press_en;
    div_in_side.shift    = s11_side_r.shift;
    div_in_side.zero     = s11_side_r.zero;
    div_in_side.temp     = s11_side_r.temp;
    div_in_side.hum      = s11_side_r.hum;
  end

  ensc_pkg::side_t div_side;
  logic [31:0]     div_quo;

  ensc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_side  (div_in_side),
    .in_dvd   (s11_dvd_r),
    .in_dvs   (s11_dvs_r),
    .out_side (div_side),
    .out_quo  (div_quo)
  );

  // Pressure back end.
  ensc_pkg::side_t q1_side_r, q2_side_r;
  logic [31:0]        q1_p_r, q1_xx_r, q2_p_r, pq, px;
  logic signed [31:0] q1_pb_r, q2_m9_r, q2_pb8_r, ps, pf_s;
  logic [31:0]        pf;
  logic [16:0]        press17;

  assign pq = div_side.shift ? {div_quo[30:0], 1'b0} : div_quo;
  assign px = pq >> 3;

  always_comb begin
    ps   = ensc_pkg::sdiv(ensc_pkg::sdiv(q2_m9_r, 5'd12) + q2_pb8_r + p7, 5'd4);
    pf_s = $signed(q2_p_r) + ps;
    pf   = $unsigned(pf_s);
    if (pf < ensc_pkg::PRESS_MIN) begin
      pf = ensc_pkg::PRESS_MIN;
    end else if (pf > ensc_pkg::PRESS_MAX) begin
      pf = ensc_pkg::PRESS_MAX;
    end
    if (q2_side_r.zero) begin
      pf = ensc_pkg::PRESS_MIN;
    end
    press17 = q2_side_r.press_en ? pf[16:0] : 17'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q1_side_r   <= '0;
      q2_side_r   <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      q1_side_r   <= div_side;
      q2_side_r   <= q1_side_r;
      out_valid_r <= q2_side_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q1_p_r           <= pq;
      q1_xx_r          <= px * px;
      q1_pb_r          <= $signed({2'b0, pq[31:2]}) * p8;
      q2_p_r           <= q1_p_r;
      q2_m9_r          <= p9 * $signed({13'b0, q1_xx_r[31:13]});
      q2_pb8_r         <= ensc_pkg::sdiv(q1_pb_r, 5'd13);
      out_temp_centi_c <= $signed(q2_side_r.temp);
      out_pressure_pa  <= press17;
      out_humidity_q10 <= q2_side_r.hum;
    end
  end

  assign out_valid = out_valid_r;

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temp_centi_c >= -15'sd4000 && out_temp_centi_c <= 15'sd8500))
    else $error("temperature out of range");

  a_press_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_pressure_pa == 17'd0 ||
                   (out_pressure_pa >= 17'd30000 && out_pressure_pa <= 17'd110000)))
    else $error("pressure out of range");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_humidity_q10 <= 17'd102400))
    else $error("humidity out of range");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> $stable(v_r) && $stable(q1_side_r.valid))
    else $error("pipeline moved while frozen");

endmodule

// ----- tb/env_sensor_compensation_test.sv -----
module env_sensor_compensation_test;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [14:0] temp;
    logic [16:0]        press;
    logic [16:0]        hum;
  } reading_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [19:0]        in_raw_temperature;
  logic [19:0]        in_raw_pressure;
  logic [15:0]        in_raw_humidity;
  logic [2:0]         in_func;
  logic               out_valid;
  logic               out_stall;
  logic signed [14:0] out_temp_centi_c;
  logic [16:0]        out_pressure_pa;
  logic [16:0]        out_humidity_q10;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [63:0]        cfg_data;

  // Calibration words as the testbench believes the block holds them.
  logic [47:0] cal_temp;
  logic [63:0] cal_press_a;
  logic [63:0] cal_press_b;
  logic [15:0] cal_press_c;
  logic [63:0] cal_hum;

  reading_t expected_readings[$];
  int       errors;
  int       beats_sent;
  int       beats_checked;
  bit       no_idle;
  int       hold_cycles;
  int       stall_left;

  env_sensor_compensation i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  function automatic int cal_field(logic [63:0] v, int pos, int w, bit sgn);
    logic [31:0] f;
    f = 32'((v >> pos) & ((64'd1 << w) - 64'd1));
    if (sgn && f[w-1]) f = f | ~((32'd1 << w) - 32'd1);
    return int'(f);
  endfunction

  function automatic int fine_temp(int unsigned rt);
    int t1, t2, t3, a, b;
    t1 = cal_field(cal_temp, 0, 16, 1'b0);
    t2 = cal_field(cal_temp, 16, 16, 1'b1);
    t3 = cal_field(cal_temp, 32, 16, 1'b1);
    a = int'(rt / 8 - unsigned'(t1 * 2));
    a = (a * t2) / 2048;
    b = int'(rt / 16 - unsigned'(t1));
    b = (((b * b) / 4096) * t3) / 16384;
    return a + b;
  endfunction

  function automatic int unsigned pressure_pa(int fine, int unsigned rp);
    int p1, p2, p3, p4, p5, p6, p7, p8, p9, a, b, c, d, q;
    int unsigned p, dv;
    p1 = cal_field(cal_press_a, 0, 16, 1'b0);
    p2 = cal_field(cal_press_a, 16, 16, 1'b1);
    p3 = cal_field(cal_press_a, 32, 16, 1'b1);
    p4 = cal_field(cal_press_a, 48, 16, 1'b1);
    p5 = cal_field(cal_press_b, 0, 16, 1'b1);
    p6 = cal_field(cal_press_b, 16, 16, 1'b1);
    p7 = cal_field(cal_press_b, 32, 16, 1'b1);
    p8 = cal_field(cal_press_b, 48, 16, 1'b1);
    p9 = cal_field({48'd0, cal_press_c}, 0, 16, 1'b1);
    a = fine / 2 - 64000;
    q = a / 4;
    b = ((q * q) / 2048) * p6;
    b = b + (a * p5) * 2;
    b = b / 4 + p4 * 65536;
    c = (p3 * ((q * q) / 8192)) / 8;
    d = (p2 * a) / 2;
    a = (c + d) / 262144;
    a = ((32768 + a) * p1) / 32768;
    if (a == 0) return ensc_pkg::PRESS_MIN;
    dv = unsigned'(a);
    p = ((32'd1048576 - rp) - unsigned'(b / 4096)) * 32'd3125;
    if (p < 32'h8000_0000) p = (p << 1) / dv;
    else p = (p / dv) * 32'd2;
    a = (p9 * int'(((p / 32'd8) * (p / 32'd8)) / 32'd8192)) / 4096;
    b = (int'(p / 32'd4) * p8) / 8192;
    p = unsigned'(int'(p) + (a + b + p7) / 16);
    if (p < ensc_pkg::PRESS_MIN) p = ensc_pkg::PRESS_MIN;
    else if (p > ensc_pkg::PRESS_MAX) p = ensc_pkg::PRESS_MAX;
    return p;
  endfunction

  function automatic int unsigned humidity_q10(int fine, int unsigned rh);
    int h1, h2, h3, h4, h5, h6, d, a, b, c, e;
    h1 = cal_field(cal_hum, 0, 8, 1'b0);
    h2 = cal_field(cal_hum, 8, 16, 1'b1);
    h3 = cal_field(cal_hum, 24, 8, 1'b0);
    h4 = cal_field(cal_hum, 32, 12, 1'b1);
    h5 = cal_field(cal_hum, 44, 12, 1'b1);
    h6 = cal_field(cal_hum, 56, 8, 1'b1);
    d = fine - 76800;
    a = int'(rh * 32'd16384);
    b = h4 * 1048576;
    c = h5 * d;
    e = (a - b - c + 16384) / 32768;
    a = (d * h6) / 1024;
    b = (d * h3) / 2048;
    c = (a * (b + 32768)) / 1024 + 2097152;
    a = (c * h2 + 8192) / 16384;
    b = e * a;
    c = ((b / 32768) * (b / 32768)) / 128;
    e = b - (c * h1) / 16;
    if (e < 0) e = 0;
    if (e > ensc_pkg::HUM_VAR_MAX) e = ensc_pkg::HUM_VAR_MAX;
    e = e / 4096;
    return (e > 102400) ? 32'd102400 : unsigned'(e);
  endfunction

  function automatic reading_t compensate(logic [19:0] rt, logic [19:0] rp,
                                          logic [15:0] rh, logic [2:0] fn);
    reading_t r;
    int fine, t;
    r = '0;
    if (fn != 3'd0) begin
      fine = fine_temp(rt);
      t = (fine * 5 + 128) / 256;
      if (t < ensc_pkg::TEMP_MIN) t = ensc_pkg::TEMP_MIN;
      else if (t > ensc_pkg::TEMP_MAX) t = ensc_pkg::TEMP_MAX;
      r.temp = t[14:0];
      if (fn[1]) r.press = 17'(pressure_pa(fine, rp));
      if (fn[2]) r.hum = 17'(humidity_q10(fine, rh));
    end
    return r;
  endfunction

  task automatic report(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // Results are checked at the rising edge where the beat is taken.
  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_readings.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        want = expected_readings.pop_front();
        if (out_temp_centi_c !== want.temp)
          report("temperature", out_temp_centi_c, want.temp);
        if (out_pressure_pa !== want.press)
          report("pressure", out_pressure_pa, want.press);
        if (out_humidity_q10 !== want.hum)
          report("humidity", out_humidity_q10, want.hum);
        beats_checked++;
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 8);
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall = 1'b1;
      hold_cycles--;
    end else if (stall_left > 0) begin
      out_stall = 1'b1;
      stall_left--;
    end else begin
      out_stall = 1'b0;
    end
  end

  task automatic send_reading(logic [19:0] rt, logic [19:0] rp,
                              logic [15:0] rh, logic [2:0] fn);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_raw_temperature = rt;
    in_raw_pressure    = rp;
    in_raw_humidity    = rh;
    in_func            = fn;
    in_valid           = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_readings.push_back(compensate(rt, rp, rh, fn));
    beats_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_calib(logic [2:0] idx, logic [63:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    case (idx)
      ensc_pkg::REG_TEMP_CALIB:    cal_temp    = value[47:0];
      ensc_pkg::REG_PRESS_CALIB_A: cal_press_a = value;
      ensc_pkg::REG_PRESS_CALIB_B: cal_press_b = value;
      ensc_pkg::REG_PRESS_CALIB_C: cal_press_c = value[15:0];
      ensc_pkg::REG_HUM_CALIB:     cal_hum     = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_calib(logic [63:0] t, logic [63:0] pa, logic [63:0] pb,
                            logic [63:0] pc, logic [63:0] h);
    drain();
    write_calib(ensc_pkg::REG_TEMP_CALIB, t);
    write_calib(ensc_pkg::REG_PRESS_CALIB_A, pa);
    write_calib(ensc_pkg::REG_PRESS_CALIB_B, pb);
    write_calib(ensc_pkg::REG_PRESS_CALIB_C, pc);
    write_calib(ensc_pkg::REG_HUM_CALIB, h);
  endtask

  // A calibration set typical of a real part.
  task automatic load_typical_calib;
    load_calib({16'(-1000), 16'd26435, 16'd27504},
               {16'd2855, 16'd3024, 16'(-10685), 16'd36477},
               {16'(-14600), 16'd15500, 16'(-7), 16'd140},
               64'd6000,
               {8'd30, 12'd50, 12'd313, 8'd0, 16'd362, 8'd75});
  endtask

  task automatic send_near_room(logic [2:0] fn);
    send_reading(20'(519888 + int'($urandom_range(0, 160000)) - 80000),
                 20'(415148 + int'($urandom_range(0, 300000)) - 150000),
                 16'($urandom_range(0, 65535)), fn);
  endtask

  task automatic send_any;
    send_reading(20'($urandom), 20'($urandom), 16'($urandom), 3'($urandom));
  endtask

  // Empty mask, each channel alone, zero pressure divisor, raw extremes.
  task automatic test_directed;
    for (int f = 0; f < 8; f++) send_reading(20'd519888, 20'd415148, 16'd30000, 3'(f));
    send_reading(20'd0, 20'd0, 16'd0, 3'd7);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 3'd7);
    load_typical_calib();
    for (int f = 0; f < 8; f++) send_reading(20'd519888, 20'd415148, 16'd30000, 3'(f));
    send_reading(20'd0, 20'd0, 16'd0, 3'd7);
    send_reading(20'hFFFFF, 20'hFFFFF, 16'hFFFF, 3'd7);
    send_reading(20'd0, 20'hFFFFF, 16'd0, 3'd6);
    send_reading(20'hFFFFF, 20'd0, 16'hFFFF, 3'd6);
  endtask

  task automatic test_typical_random;
    load_typical_calib();
    for (int i = 0; i < 700; i++) begin
      no_idle = (i >= 300 && i < 400);
      if ($urandom_range(0, 9) == 0) send_any();
      else send_near_room(3'($urandom));
    end
    no_idle = 1'b0;
  endtask

  task automatic test_random_calib;
    for (int phase = 0; phase < 6; phase++) begin
      load_calib({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
      for (int i = 0; i < 100; i++) send_any();
    end
  endtask

  task automatic test_extreme_calib;
    load_calib('1, '1, '1, '1, '1);
    for (int i = 0; i < 100; i++) send_any();
    load_calib(64'h8000_8000_8000, 64'h8000_8000_8000_FFFF, 64'h8000_8000_8000_8000,
               64'h8000, 64'h80_800_800_FF_8000_FF);
    for (int i = 0; i < 100; i++) send_any();
  endtask

  // The receiver holds off long enough for the pipeline to fill and push back.
  task automatic test_backpressure;
    load_typical_calib();
    no_idle = 1'b1;
    @(negedge clk);
    hold_cycles = 300;
    for (int i = 0; i < 150; i++) send_near_room(3'($urandom));
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_raw_temperature = '0;
    in_raw_pressure = '0;
    in_raw_humidity = '0;
    in_func = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = ensc_pkg::REG_TEMP_CALIB;
    cfg_data = '0;
    cal_temp = '0;
    cal_press_a = '0;
    cal_press_b = '0;
    cal_press_c = '0;
    cal_hum = '0;
    errors = 0;
    beats_sent = 0;
    beats_checked = 0;
    no_idle = 1'b0;
    hold_cycles = 0;
    stall_left = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_typical_random();
    test_random_calib();
    test_extreme_calib();
    test_backpressure();
    drain();

    $display("covered directed masks and extremes, typical, random and extreme calibration,");
    $display("and a long receiver hold: %0d readings sent, %0d results checked",
             beats_sent, beats_checked);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- env_sensor_compensation.f -----
design/ensc_pkg.sv
design/ensc_div.sv
design/env_sensor_compensation.sv
tb/env_sensor_compensation_test.sv
